// File: rtl/bca_pkg.sv
// Shared constants, codes and types of the block chain allocator.
package bca_pkg;

	// Block geometry.
	localparam int NUM_BLOCKS = 4096;
	localparam int BLK_W      = 12;
	localparam int LINK_W     = 13;
	localparam int CNT_W      = 13;

	// Link markers.
	localparam logic [LINK_W-1:0] LINK_END   = 13'h1FFF;
	localparam logic [LINK_W-1:0] LINK_FREED = 13'h1FFE;

	// Operation codes.
	localparam logic [2:0] OP_ALLOC  = 3'd0;
	localparam logic [2:0] OP_EXTEND = 3'd1;
	localparam logic [2:0] OP_FREE   = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_LOAD   = 3'd4;

	// Status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
	localparam logic [1:0] STATUS_BAD      = 2'd2;

	// One command transfer.
	typedef struct packed {
		logic [2:0]        operation;
		logic [BLK_W-1:0]  block;
		logic [CNT_W-1:0]  count;
		logic              load_free;
		logic [LINK_W-1:0] load_link;
	} cmd_t;

	// One result transfer.
	typedef struct packed {
		logic [1:0]        status;
		logic [BLK_W-1:0]  result_block;
		logic [LINK_W-1:0] link;
		logic [CNT_W-1:0]  freed_count;
		logic [CNT_W-1:0]  free_count;
	} result_t;

	// One table entry: free bit and link, kept together in one memory word.
	typedef struct packed {
		logic              free;
		logic [LINK_W-1:0] link;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller states.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC,
		S_ALLOC_END,
		S_EXT_CHK,
		S_EXT_LINK,
		S_FREE,
		S_READ,
		S_LOAD
	} state_t;

endpackage

// File: rtl/bca_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/block_chain_allocator.sv
// Top level of the block chain allocator: controller around one table memory.
//
// A command transfer is taken at a rising edge where start is high and busy is
// low. The command carries an operation, a block index, a chain length and the
// entry to write for a load. Every command gives exactly one result, shown on
// result for one cycle while done is high; the receiver takes it then and
// cannot hold it off.
//
// Free bit and link of every block share one 4096-entry memory with a registered
// read. A bad opcode, a zero length or a too long allocate is answered straight
// from idle; read link and load entry pass through one more state; allocate
// scans for the N-th free block and end-marks the last one; extend checks the
// tail, then scans for the first free block, end-marks it and links the old
// tail to it, or is refused right after the check; free chain walks the chain
// block by block and stops at its end or at a block that is already free.
// The first-fit scan and the chain walk make one memory read per cycle, and
// busy stays high until the result is out.
// After reset a clearing pass writes every entry as free with busy high; then
// the block takes commands.
module block_chain_allocator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bca_pkg::cmd_t    cmd,
	output logic             done,
	output bca_pkg::result_t result
);

	localparam int BLK_W  = bca_pkg::BLK_W;
	localparam int LINK_W = bca_pkg::LINK_W;
	localparam int CNT_W  = bca_pkg::CNT_W;

	bca_pkg::state_t  state_q, state_d;
	logic [BLK_W-1:0] addr_q, addr_d;
	logic [BLK_W-1:0] addr_s1;
	logic             vld_s1, vld_d;
	bca_pkg::cmd_t    req_q, req_d;
	logic [CNT_W-1:0] remain_q, remain_d;
	logic [BLK_W-1:0] prev_q, prev_d;
	logic             first_q, first_d;
	logic [CNT_W-1:0] freed_q, freed_d;
	logic [CNT_W-1:0] total_q, total_d;
	bca_pkg::result_t res_q, res_d;
	logic             done_q, done_d;

	logic                      we;
	logic [BLK_W-1:0]          waddr;
	bca_pkg::entry_t           wdata;
	logic [BLK_W-1:0]          rd_addr;
	logic [bca_pkg::ENTRY_W-1:0] rdata_raw;
	bca_pkg::entry_t           rdata;

	// Table memory: free bit and link of every block.
	bca_ram #(
		.WIDTH(bca_pkg::ENTRY_W),
		.DEPTH(bca_pkg::NUM_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata_raw)
	);

	assign rdata = bca_pkg::entry_t'(rdata_raw);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bca_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			vld_s1  <= 1'b0;
			first_q <= 1'b0;
			total_q <= CNT_W'(bca_pkg::NUM_BLOCKS);
			done_q  <= 1'b0;
		end else begin
			addr_q  <= addr_d;
			vld_s1  <= vld_d;
			first_q <= first_d;
			total_q <= total_d;
			done_q  <= done_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		addr_s1  <= rd_addr;
		req_q    <= req_d;
		remain_q <= remain_d;
		prev_q   <= prev_d;
		freed_q  <= freed_d;
		res_q    <= res_d;
	end

	// Next state, memory accesses and result.
	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		vld_d    = 1'b0;
		req_d    = req_q;
		remain_d = remain_q;
		prev_d   = prev_q;
		first_d  = first_q;
		freed_d  = freed_q;
		total_d  = total_q;
		res_d    = res_q;
		done_d   = 1'b0;
		we       = 1'b0;
		waddr    = addr_q;
		wdata    = '0;
		rd_addr  = addr_q;

		case (state_q)
			// Clearing pass: mark every entry free, one per cycle.
			bca_pkg::S_CLEAR: begin
				we     = 1'b1;
				waddr  = addr_q;
				wdata  = '{free: 1'b1, link: bca_pkg::LINK_FREED};
				addr_d = addr_q + 1'b1;
				if (addr_q == BLK_W'(bca_pkg::NUM_BLOCKS - 1)) begin
					state_d = bca_pkg::S_IDLE;
				end
			end

			// Take a command; the read of its block is issued right away.
			bca_pkg::S_IDLE: begin
				rd_addr = cmd.block;
				if (start) begin
					req_d            = cmd;
					res_d            = '0;
					res_d.free_count = total_q;
					case (cmd.operation)
						bca_pkg::OP_ALLOC: begin
							if (cmd.count == '0) begin
								res_d.status = bca_pkg::STATUS_BAD;
								done_d       = 1'b1;
							end else if (cmd.count > total_q) begin
								res_d.status = bca_pkg::STATUS_NO_SPACE;
								done_d       = 1'b1;
							end else begin
								remain_d = cmd.count;
								first_d  = 1'b1;
								addr_d   = '0;
								state_d  = bca_pkg::S_ALLOC;
							end
						end
						bca_pkg::OP_EXTEND: begin
							state_d = bca_pkg::S_EXT_CHK;
						end
						bca_pkg::OP_FREE: begin
							first_d = 1'b1;
							freed_d = '0;
							state_d = bca_pkg::S_FREE;
						end
						bca_pkg::OP_READ: begin
							state_d = bca_pkg::S_READ;
						end
						bca_pkg::OP_LOAD: begin
							state_d = bca_pkg::S_LOAD;
						end
						default: begin
							res_d.status = bca_pkg::STATUS_BAD;
							done_d       = 1'b1;
						end
					endcase
				end
			end

			// First-fit scan: one read per cycle; each free block found links
			// the previous one to it.
			bca_pkg::S_ALLOC: begin
				rd_addr = addr_q;
				addr_d  = addr_q + 1'b1;
				vld_d   = 1'b1;
				if (vld_s1 && rdata.free) begin
					if (first_q) begin
						res_d.result_block = addr_s1;
					end else begin
						we    = 1'b1;
						waddr = prev_q;
						wdata = '{free: 1'b0, link: LINK_W'(addr_s1)};
					end
					prev_d   = addr_s1;
					first_d  = 1'b0;
					remain_d = remain_q - 1'b1;
					total_d  = total_q - 1'b1;
					if (remain_q == CNT_W'(1)) begin
						vld_d   = 1'b0;
						state_d = bca_pkg::S_ALLOC_END;
					end
				end
			end

			// End-mark the last block of the new chain.
			bca_pkg::S_ALLOC_END: begin
				we    = 1'b1;
				waddr = prev_q;
				wdata = '{free: 1'b0, link: bca_pkg::LINK_END};
				if (req_q.operation == bca_pkg::OP_EXTEND) begin
					state_d = bca_pkg::S_EXT_LINK;
				end else begin
					res_d.free_count = total_q;
					done_d           = 1'b1;
					state_d          = bca_pkg::S_IDLE;
				end
			end

			// Extend: the given block must be in use and end its chain.
			bca_pkg::S_EXT_CHK: begin
				if (rdata.free || rdata.link != bca_pkg::LINK_END) begin
					res_d.status = bca_pkg::STATUS_BAD;
					done_d       = 1'b1;
					state_d      = bca_pkg::S_IDLE;
				end else if (total_q == '0) begin
					res_d.status = bca_pkg::STATUS_NO_SPACE;
					done_d       = 1'b1;
					state_d      = bca_pkg::S_IDLE;
				end else begin
					remain_d = CNT_W'(1);
					first_d  = 1'b1;
					addr_d   = '0;
					state_d  = bca_pkg::S_ALLOC;
				end
			end

			// Extend: link the old tail to the new block.
			bca_pkg::S_EXT_LINK: begin
				we                 = 1'b1;
				waddr              = req_q.block;
				wdata              = '{free: 1'b0, link: LINK_W'(prev_q)};
				res_d.result_block = prev_q;
				res_d.free_count   = total_q;
				done_d             = 1'b1;
				state_d            = bca_pkg::S_IDLE;
			end

			// Chain walk: free the current block and read its successor in the
			// same cycle; a link past the last block or back to itself ends the walk without a read.
			bca_pkg::S_FREE: begin
				if (rdata.free) begin
					if (first_q) begin
						res_d.status = bca_pkg::STATUS_BAD;
					end else begin
						res_d.freed_count = freed_q;
						res_d.free_count  = total_q;
					end
					done_d  = 1'b1;
					state_d = bca_pkg::S_IDLE;
				end else begin
					we      = 1'b1;
					waddr   = addr_s1;
					wdata   = '{free: 1'b1, link: bca_pkg::LINK_FREED};
					freed_d = freed_q + 1'b1;
					total_d = total_q + 1'b1;
					first_d = 1'b0;
					if (rdata.link >= LINK_W'(bca_pkg::NUM_BLOCKS) ||
					    rdata.link[BLK_W-1:0] == addr_s1) begin
						res_d.freed_count = freed_d;
						res_d.free_count  = total_d;
						done_d            = 1'b1;
						state_d           = bca_pkg::S_IDLE;
					end else begin
						rd_addr = rdata.link[BLK_W-1:0];
					end
				end
			end

			// Read one link.
			bca_pkg::S_READ: begin
				res_d.link = rdata.link;
				done_d     = 1'b1;
				state_d    = bca_pkg::S_IDLE;
			end

			// Load one entry and keep the free count in step with the free bit.
			bca_pkg::S_LOAD: begin
				we    = 1'b1;
				waddr = req_q.block;
				wdata = '{free: req_q.load_free, link: req_q.load_link};
				if (req_q.load_free && !rdata.free) begin
					total_d = total_q + 1'b1;
				end else if (!req_q.load_free && rdata.free) begin
					total_d = total_q - 1'b1;
				end
				res_d.free_count = total_d;
				done_d           = 1'b1;
				state_d          = bca_pkg::S_IDLE;
			end

			default: begin
				state_d = bca_pkg::S_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != bca_pkg::S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// The free count never exceeds the number of blocks.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(bca_pkg::NUM_BLOCKS))
		else $error("free count above block count");

	// No result leaves during the clearing pass.
	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bca_pkg::S_CLEAR) |-> !done_q)
		else $error("result during clearing pass");

	// Allocation writes only mark blocks as in use.
	a_alloc_write: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (state_q == bca_pkg::S_ALLOC || state_q == bca_pkg::S_ALLOC_END ||
		        state_q == bca_pkg::S_EXT_LINK)) |-> !wdata.free)
		else $error("allocation wrote a free entry");

	// The scan only runs while blocks remain to be taken.
	a_scan_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bca_pkg::S_ALLOC) |-> (remain_q != '0))
		else $error("scan running with nothing left to allocate");

endmodule
